FILE: rtl/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg
// shared types, register indexes and helpers for the perspective projector
// ----------------------------------------------------------------------------
package fpp_pkg;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic signed [31:0] depth;
    logic               zero_depth;
  } pixel_t;

  // configuration register file, index 0 in the low word
  typedef logic [7:0][63:0] cfg_regs_t;

  localparam int NUM_REGS = 8;
  localparam logic [2:0] REG_ROW0_FIRST  = 3'd0;
  localparam logic [2:0] REG_ROW0_SECOND = 3'd1;
  localparam logic [2:0] REG_ROW1_FIRST  = 3'd2;
  localparam logic [2:0] REG_ROW1_SECOND = 3'd3;
  localparam logic [2:0] REG_ROW2_FIRST  = 3'd4;
  localparam logic [2:0] REG_ROW2_SECOND = 3'd5;
  localparam logic [2:0] REG_SCALES      = 3'd6;
  localparam logic [2:0] REG_CENTRE      = 3'd7;

  // quotient bits kept by the reciprocal unit
  localparam int QUOT_BITS = 33;

  // data carried alongside the reciprocal pipeline
  typedef struct packed {
    logic signed [31:0] t_x;
    logic signed [31:0] t_y;
    logic signed [31:0] depth;
    logic               zero;
    logic               cz_pos;
    logic               big;
    logic [31:0]        divisor;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/fpp_cam.sv
// ----------------------------------------------------------------------------
// fpp_cam
// view matrix transform: products in one stage, sum of truncated products, saturated, in the next
// ----------------------------------------------------------------------------
module fpp_cam #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  fpp_pkg::point_t     pt,
  input  fpp_pkg::cfg_regs_t  regs,
  output logic                out_valid,
  output logic signed [31:0]  cx,
  output logic signed [31:0]  cy,
  output logic signed [31:0]  cz
);

  logic               pv;
  logic signed [63:0] prod [3][3];
  logic signed [31:0] trans [3];
  logic signed [31:0] m [3][3];
  logic signed [65:0] acc [3];
  logic signed [31:0] cam [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      m[r][0] = regs[2*r][31:0];
      m[r][1] = regs[2*r][63:32];
      m[r][2] = regs[2*r+1][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= in_valid;
    end
    for (int r = 0; r < 3; r++) begin
      prod[r][0] <= 64'(m[r][0]) * 64'(pt.world_x);
      prod[r][1] <= 64'(m[r][1]) * 64'(pt.world_y);
      prod[r][2] <= 64'(m[r][2]) * 64'(pt.world_z);
      trans[r]   <= regs[2*r+1][63:32];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 66'(prod[r][0] >>> FRAC_BITS) + 66'(prod[r][1] >>> FRAC_BITS)
             + 66'(prod[r][2] >>> FRAC_BITS) + 66'(trans[r]);
      cam[r] = fpp_pkg::sat32(acc[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pv;
    end
    cx <= cam[0];
    cy <= cam[1];
    cz <= cam[2];
  end

endmodule

FILE: rtl/fpp_div_step.sv
// ----------------------------------------------------------------------------
// fpp_div_step
// one restoring-division stage, one quotient bit of the reciprocal
// ----------------------------------------------------------------------------
module fpp_div_step #(
  parameter int FRAC_BITS = 16,
  parameter int BIT       = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [31:0]                 in_rem,
  input  logic [fpp_pkg::QUOT_BITS-1:0] in_quot,
  input  fpp_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [31:0]                 out_rem,
  output logic [fpp_pkg::QUOT_BITS-1:0] out_quot,
  output fpp_pkg::side_t              out_side
);

  // dividend is a single one at bit 2*FRAC_BITS
  localparam logic DBIT = (BIT == 2 * FRAC_BITS);

  logic [32:0] trial;
  logic        fits;

  assign trial = {in_rem, DBIT};
  assign fits  = trial >= {1'b0, in_side.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= fits ? 32'(trial - {1'b0, in_side.divisor}) : trial[31:0];
    out_quot <= {in_quot[fpp_pkg::QUOT_BITS-2:0], fits};
    out_side <= in_side;
  end

endmodule

FILE: rtl/fixed_point_perspective_projection_top.sv
// ----------------------------------------------------------------------------
// fixed_point_perspective_projection_top
// pinhole projection of world points through a 3x4 view matrix
// ----------------------------------------------------------------------------
// A point is taken on every cycle that start is high (busy never rises), and
// its word comes out on result with done high for one cycle, in order. The
// receiver cannot stall, so every result must be taken when shown. The pipe
// holds two matrix stages, one setup stage and one scale stage, then a
// restoring divider for the reciprocal with one stage per quotient bit (33
// stages), then four stages for the signed reciprocal, the final products and
// sums.
// Configuration writes are always ready and take effect at once; write only
// while no point is in flight.
module fixed_point_perspective_projection_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  fpp_pkg::point_t world,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  output logic            done,
  output fpp_pkg::pixel_t result
);

  localparam int QB = fpp_pkg::QUOT_BITS;
  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  // quotient of 2^(2F) by |cz| overflows 33 bits when |cz| is this small
  localparam bit HAS_BIG = (2 * FRAC_BITS >= QB);
  localparam logic [31:0] BIG_LIMIT =
    HAS_BIG ? 32'(64'd1 << (HAS_BIG ? 2 * FRAC_BITS - QB : 0)) : 32'd0;
  // remainder after the dividend bits above the quotient window
  localparam logic [31:0] REM_INIT = BIG_LIMIT;

  fpp_pkg::cfg_regs_t regs;

  // no back pressure anywhere in the pipe
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // register file, identity view at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[fpp_pkg::REG_ROW0_FIRST]  <= ONE;
      regs[fpp_pkg::REG_ROW0_SECOND] <= '0;
      regs[fpp_pkg::REG_ROW1_FIRST]  <= ONE << 32;
      regs[fpp_pkg::REG_ROW1_SECOND] <= '0;
      regs[fpp_pkg::REG_ROW2_FIRST]  <= '0;
      regs[fpp_pkg::REG_ROW2_SECOND] <= ONE;
      regs[fpp_pkg::REG_SCALES]      <= '0;
      regs[fpp_pkg::REG_CENTRE]      <= '0;
    end else if (cfg_valid && cfg_index < 8'(fpp_pkg::NUM_REGS)) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  // camera coordinates
  logic               cam_valid;
  logic signed [31:0] cx, cy, cz;

  fpp_cam #(.FRAC_BITS(FRAC_BITS)) u_cam (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .pt       (world),
    .regs     (regs),
    .out_valid(cam_valid),
    .cx       (cx),
    .cy       (cy),
    .cz       (cz)
  );

  // setup: scale products, |cz|, depth, flags
  logic               s3_valid;
  logic signed [63:0] s3_px, s3_py;
  logic signed [31:0] s3_depth;
  logic               s3_zero, s3_pos, s3_big;
  logic [31:0]        s3_d;
  logic [31:0]        acz;

  assign acz = cz[31] ? 32'(-{1'b0, cz}) : cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= cam_valid;
    end
    s3_px    <= 64'(cx) * 64'($signed(regs[fpp_pkg::REG_SCALES][31:0]));
    s3_py    <= 64'(cy) * 64'($signed(regs[fpp_pkg::REG_SCALES][63:32]));
    s3_depth <= fpp_pkg::sat32(-66'(cz));
    s3_zero  <= (cz == 32'sd0);
    s3_pos   <= !cz[31] && (cz != 32'sd0);
    s3_big   <= HAS_BIG && (acz <= BIG_LIMIT);
    s3_d     <= acz;
  end

  // truncate scale products, enter divider
  logic           dv    [QB+1];
  logic [31:0]    drem  [QB+1];
  logic [QB-1:0]  dquot [QB+1];
  fpp_pkg::side_t dside [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= s3_valid;
    end
    drem[0]  <= REM_INIT;
    dquot[0] <= '0;
    dside[0].t_x     <= fpp_pkg::sat32(66'(s3_px >>> FRAC_BITS));
    dside[0].t_y     <= fpp_pkg::sat32(66'(s3_py >>> FRAC_BITS));
    dside[0].depth   <= s3_depth;
    dside[0].zero    <= s3_zero;
    dside[0].cz_pos  <= s3_pos;
    dside[0].big     <= s3_big;
    dside[0].divisor <= s3_d;
  end

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < QB; i++) begin : g_div
    fpp_div_step #(.FRAC_BITS(FRAC_BITS), .BIT(QB - 1 - i)) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv[i]),
      .in_rem   (drem[i]),
      .in_quot  (dquot[i]),
      .in_side  (dside[i]),
      .out_valid(dv[i+1]),
      .out_rem  (drem[i+1]),
      .out_quot (dquot[i+1]),
      .out_side (dside[i+1])
    );
  end

  // signed, saturated reciprocal
  logic               q_valid;
  logic signed [31:0] q;
  fpp_pkg::side_t     q_side;
  fpp_pkg::side_t     fs;
  logic [QB-1:0]      quot;

  assign fs   = dside[QB];
  assign quot = dquot[QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= dv[QB];
    end
    q_side <= fs;
    if (fs.cz_pos) begin
      if (fs.big || quot > QB'(33'h0_8000_0000)) begin
        q <= 32'sh8000_0000;
      end else begin
        q <= 32'(-quot);
      end
    end else begin
      if (fs.big || quot >= QB'(33'h0_8000_0000)) begin
        q <= 32'sh7FFF_FFFF;
      end else begin
        q <= quot[31:0];
      end
    end
  end

  // products with the reciprocal
  logic               m_valid;
  logic signed [63:0] m_x, m_y;
  logic signed [31:0] m_depth;
  logic               m_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= q_valid;
    end
    m_x     <= 64'(q_side.t_x) * 64'(q);
    m_y     <= 64'(q_side.t_y) * 64'(q);
    m_depth <= q_side.depth;
    m_zero  <= q_side.zero;
  end

  // truncate and saturate the products
  logic               n_valid;
  logic signed [31:0] n_x, n_y, n_depth;
  logic               n_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else begin
      n_valid <= m_valid;
    end
    n_x     <= fpp_pkg::sat32(66'(m_x >>> FRAC_BITS));
    n_y     <= fpp_pkg::sat32(66'(m_y >>> FRAC_BITS));
    n_depth <= m_depth;
    n_zero  <= m_zero;
  end

  // add optical centre, force zero on degenerate depth, output word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= n_valid;
    end
    result.pixel_x <= n_zero ? 32'sd0 : fpp_pkg::sat32(66'(n_x)
                      + 66'($signed(regs[fpp_pkg::REG_CENTRE][31:0])));
    result.pixel_y <= n_zero ? 32'sd0 : fpp_pkg::sat32(66'(n_y)
                      + 66'($signed(regs[fpp_pkg::REG_CENTRE][63:32])));
    result.depth      <= n_depth;
    result.zero_depth <= n_zero;
  end

endmodule

FILE: tb/sv/fixed_point_perspective_projection_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_perspective_projection_top_test
// drives world points through the projector under several view matrices and
// compares every pixel word with an in-bench fixed-point prediction
// ----------------------------------------------------------------------------
module fixed_point_perspective_projection_top_test;

  localparam int FRAC = 16;
  localparam int LATENCY = 41;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [7:0] REG_OUT_OF_RANGE = 8'd9;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  fpp_pkg::point_t world;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [63:0] cfg_data;
  logic done;
  fpp_pkg::pixel_t result;

  // shadow of the view matrix, scales and centre
  logic [63:0] view_regs [fpp_pkg::NUM_REGS];
  fpp_pkg::pixel_t pending_pixels[$];
  int error_count;
  int idle_cycles;

  fixed_point_perspective_projection_top #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .world(world),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // exact product, floor shift by the fraction width
  function automatic longint fix_mul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint half_of(input int idx, input bit upper);
    logic signed [31:0] h;
    h = upper ? view_regs[idx][63:32] : view_regs[idx][31:0];
    return longint'(h);
  endfunction

  function automatic longint camera_coord(input int row, input longint x,
                                          input longint y, input longint z);
    return clamp32(fix_mul(half_of(2*row, 0), x) + fix_mul(half_of(2*row, 1), y)
                   + fix_mul(half_of(2*row+1, 0), z) + half_of(2*row+1, 1));
  endfunction

  function automatic fpp_pkg::pixel_t project_point(input fpp_pkg::point_t p);
    fpp_pkg::pixel_t r;
    longint cx, cy, cz, q, t;
    cx = camera_coord(0, p.world_x, p.world_y, p.world_z);
    cy = camera_coord(1, p.world_x, p.world_y, p.world_z);
    cz = camera_coord(2, p.world_x, p.world_y, p.world_z);
    r = '0;
    r.depth = 32'(clamp32(-cz));
    r.zero_depth = (cz == 0);
    if (cz != 0) begin
      // signed division truncates toward zero
      q = clamp32(-(64'sd1 <<< (2*FRAC)) / cz);
      t = clamp32(fix_mul(cx, half_of(fpp_pkg::REG_SCALES, 0)));
      t = clamp32(fix_mul(t, q));
      r.pixel_x = 32'(clamp32(t + half_of(fpp_pkg::REG_CENTRE, 0)));
      t = clamp32(fix_mul(cy, half_of(fpp_pkg::REG_SCALES, 1)));
      t = clamp32(fix_mul(t, q));
      r.pixel_y = 32'(clamp32(t + half_of(fpp_pkg::REG_CENTRE, 1)));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker: done is a one-cycle strobe, no backpressure
  always @(posedge clk) begin
    fpp_pkg::pixel_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (result.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", result.pixel_x, want.pixel_x);
        if (result.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", result.pixel_y, want.pixel_y);
        if (result.depth !== want.depth)
          report_mismatch("depth", result.depth, want.depth);
        if (result.zero_depth !== want.zero_depth)
          report_mismatch("zero_depth", result.zero_depth, want.zero_depth);
      end
    end
  end

  // watchdog: cycles with no word accepted on either side
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("fixed_point_perspective_projection_top_test NOT OK");
        $finish;
      end
    end
  end

  // start drops only when a gap is actually taken
  task automatic random_gap();
    int n;
    if ($urandom_range(0, 2) == 0) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // send one point, start stays high for a following point
  task automatic send_point(input fpp_pkg::point_t p, input bit gaps);
    if (gaps) random_gap();
    start <= 1'b1;
    world <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pixels.push_back(project_point(p));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // valid stays high for a following write, callers drop it
  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < fpp_pkg::NUM_REGS) view_regs[idx] = value;
  endtask

  function automatic logic [31:0] rand_fix(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 16 << FRAC)) - (8 << FRAC));
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic fpp_pkg::point_t rand_point();
    fpp_pkg::point_t p;
    int k;
    k = $urandom_range(0, 3);
    p.world_x = rand_fix(k == 0 ? 0 : 1);
    p.world_y = rand_fix(k == 0 ? 0 : 1);
    p.world_z = rand_fix(k == 0 ? 0 : 1);
    return p;
  endfunction

  // reset values should hold after reset
  task automatic test_reset_matrix();
    fpp_pkg::point_t p;
    p = '{32'sh0001_0000, 32'sh0002_0000, 32'shFFFC_0000};
    send_point(p, 0);
    p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send_point(p, 0);
    p = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_point(p, 0);
    p = '{32'sh0, 32'sh0, 32'sh0};
    send_point(p, 0);
    drain();
  endtask

  // directed corner cases: zero depth, most negative depth, reciprocal overflow
  task automatic test_corner_cases();
    fpp_pkg::point_t p;
    write_reg(fpp_pkg::REG_SCALES, {32'sh0100_0000, 32'sh0100_0000});
    write_reg(fpp_pkg::REG_CENTRE, {32'sh0140_0000, 32'sh00F0_0000});
    write_reg(REG_OUT_OF_RANGE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(8'hFF, 64'h0);
    cfg_valid <= 1'b0;
    p = '{32'sh0003_0000, 32'shFFFE_0000, 32'sh0};
    send_point(p, 0);
    p = '{32'sh0003_0000, 32'shFFFE_0000, 32'sh8000_0000};
    send_point(p, 0);
    p = '{32'sh0003_0000, 32'shFFFE_0000, 32'sh0000_0001};
    send_point(p, 0);
    p = '{32'sh0003_0000, 32'shFFFE_0000, 32'shFFFF_FFFF};
    send_point(p, 0);
    p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'shFFFF_0000};
    send_point(p, 0);
    p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh0001_0000};
    send_point(p, 0);
    p = '{32'shFFFF_FFFF, 32'sh0, 32'sh7FFF_FFFF};
    send_point(p, 0);
    drain();
    // translation pushes cz to saturation and to -1
    write_reg(fpp_pkg::REG_ROW2_SECOND, {32'sh7FFF_FFFF, 32'sh0001_0000});
    cfg_valid <= 1'b0;
    send_point('{32'sh0, 32'sh0, 32'sh7FFF_FFFF}, 0);
    send_point('{32'sh0, 32'sh0, 32'shFFFF_0000}, 0);
    send_point('{32'sh0, 32'sh0, 32'sh8000_0000}, 0);
    drain();
  endtask

  // random points under random matrices, extremes included
  task automatic test_random_projection(input int count, input int phases);
    int per_phase;
    per_phase = count / phases;
    for (int ph = 0; ph < phases; ph++) begin
      for (int r = 0; r < fpp_pkg::NUM_REGS; r++) begin
        logic [63:0] v;
        case (ph % 4)
          0: v = {$urandom(), $urandom()};
          1: v = {32'h7FFF_FFFF, 32'h8000_0000};
          2: v = (r == 1 && ph == 2) ? 64'h0 : {32'h8000_0000, 32'h7FFF_FFFF};
          default: v = {rand_fix(2), rand_fix(2)};
        endcase
        if (ph % 4 == 3 && (r == fpp_pkg::REG_ROW2_FIRST || r == fpp_pkg::REG_ROW2_SECOND))
          v = {rand_fix(2), rand_fix(1)};
        write_reg(r[7:0], v);
      end
      cfg_valid <= 1'b0;
      for (int i = 0; i < per_phase; i++) begin
        send_point(rand_point(), (i % 200) > 60);
        // the sender holds off once until the pipe is empty
        if (i == per_phase / 2 && ph == 0) begin
          start <= 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    world = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    idle_cycles = 0;
    view_regs[0] = 64'h0000_0000_0001_0000;
    view_regs[1] = 64'h0;
    view_regs[2] = 64'h0001_0000_0000_0000;
    view_regs[3] = 64'h0;
    view_regs[4] = 64'h0;
    view_regs[5] = 64'h0000_0000_0001_0000;
    view_regs[6] = 64'h0;
    view_regs[7] = 64'h0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_matrix();
    test_corner_cases();
    test_random_projection(1840, 8);

    if (error_count == 0) begin
      $display("fixed_point_perspective_projection_top_test OK");
    end else begin
      $display("fixed_point_perspective_projection_top_test NOT OK");
    end
    $finish;
  end

endmodule
